@@ hw/rtl/timed_priority_message_queue_top_defines.svh @@
// Assertion macros for the timed priority message queue
`ifndef TIMED_PRIORITY_MESSAGE_QUEUE_TOP_DEFINES_SVH
`define TIMED_PRIORITY_MESSAGE_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define TPMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tpmq_pkg.sv @@
// ----------------------------------------------------------------------------
// tpmq_pkg
// Types, codes and sizes shared by the message queue modules.
// ----------------------------------------------------------------------------
`default_nettype none
package tpmq_pkg;
    localparam int DEPTH         = 8;
    localparam int PAYLOAD_BYTES = 256;
    localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int FILL_W        = $clog2(PAYLOAD_BYTES + 1);
    localparam int CFIFO_DEPTH   = 2;

    localparam logic [15:0] NO_DEST = 16'hFFFF;

    localparam logic [2:0] FN_CLEAR = 3'd0;
    localparam logic [2:0] FN_PUSH  = 3'd1;
    localparam logic [2:0] FN_POP   = 3'd2;
    localparam logic [2:0] FN_READY = 3'd3;
    localparam logic [2:0] FN_AWAKE = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_SPACE   = 3'd2;
    localparam logic [2:0] ST_SELF    = 3'd3;
    localparam logic [2:0] ST_BAD_IDX = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;
    localparam logic [2:0] ST_NONE    = 3'd6;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now;
        logic [15:0] pid;
        logic [7:0]  mtype;
        logic [7:0]  len;
        logic        prio;
        logic [15:0] dst;
        logic [31:0] due_tick;
        logic [31:0] expiry_tick;
        logic [2:0]  idx;
    } t_cmd;

    typedef struct packed {
        logic [15:0] pid;
        logic [7:0]  mtype;
        logic        prio;
        logic [15:0] dst;
        logic [7:0]  len;
        logic [31:0] due_tick;
        logic [31:0] expiry_tick;
    } t_entry;

    typedef struct packed {
        logic        done;
        logic [2:0]  status;
        logic [2:0]  ready_index;
        logic [31:0] wait_ticks;
        logic [3:0]  queue_count;
        logic [15:0] pid;
        logic [7:0]  mtype;
        logic        prio;
        logic [15:0] dst;
        logic [7:0]  len;
        logic        awake;
    } t_result;
endpackage
`default_nettype wire

@@ hw/rtl/tpmq_front.sv @@
// ----------------------------------------------------------------------------
// tpmq_front
// Accept command words, form send and expiry times, queue them for the back.
// ----------------------------------------------------------------------------
`default_nettype none
module tpmq_front import tpmq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [2:0]  i_func,
    input  wire logic [31:0] i_now,
    input  wire logic [15:0] i_raw_pid,
    input  wire logic [7:0]  i_msg_type,
    input  wire logic [7:0]  i_data_len,
    input  wire logic        i_priority_req,
    input  wire logic [15:0] i_dst_did,
    input  wire logic [31:0] i_send_delay,
    input  wire logic [31:0] i_expire_delay,
    input  wire logic [2:0]  i_index,
    input  wire logic        i_pop,
    output logic             o_full,
    output logic             o_head_valid,
    output t_cmd             o_head
);
    t_cmd       r_mem [CFIFO_DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push;
    logic       pop;

    assign o_full       = (r_cnt == 2'(CFIFO_DEPTH));
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_mem[r_rd];
    assign push         = i_start && !o_full;
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        n_cmd.func        = i_func;
        n_cmd.now         = i_now;
        n_cmd.pid         = i_raw_pid;
        n_cmd.mtype       = i_msg_type;
        n_cmd.len         = i_data_len;
        n_cmd.prio        = i_priority_req;
        n_cmd.dst         = i_dst_did;
        n_cmd.due_tick    = i_now + i_send_delay;
        n_cmd.expiry_tick = (i_expire_delay != 32'd0) ? i_now + i_expire_delay : 32'd0;
        n_cmd.idx         = i_index;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/tpmq_back.sv @@
// ----------------------------------------------------------------------------
// tpmq_back
// Hold the entries and carry out queued commands: clear, push, pop, ready check (purge and scan) and stay-awake query.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_priority_message_queue_top_defines.svh"
module tpmq_back import tpmq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_own_address,
    input  wire logic        i_head_valid,
    input  wire t_cmd        i_head,
    output logic             o_pop,
    output t_result          o_res
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PURGE = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    t_entry              r_ent [DEPTH];
    logic [1:0]          r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [CNT_W-1:0]    r_ptr, n_ptr;
    logic                r_pass, n_pass;
    logic [31:0]         r_wait, n_wait;
    t_result             r_res, n_res;

    logic [IDX_W-1:0]    rd_idx;
    t_entry              rd;
    logic                push_en;
    logic                rm_en;
    logic [IDX_W-1:0]    rm_pos;
    logic [CNT_W-1:0]    ptr_dec;
    logic [31:0]         diff;
    logic                awake;
    t_entry              new_ent;

    assign ptr_dec = r_ptr - CNT_W'(1);
    assign diff    = rd.due_tick - r_cmd.now;
    assign rd      = r_ent[rd_idx];
    assign o_res   = r_res;

    always_comb begin
        unique case (r_state)
            S_IDLE:  rd_idx = i_head.idx[IDX_W-1:0];
            S_PURGE: rd_idx = ptr_dec[IDX_W-1:0];
            default: rd_idx = r_ptr[IDX_W-1:0];
        endcase
    end

    always_comb begin
        awake = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if ((CNT_W'(k) < r_count) && (r_ent[k].dst == i_head.dst)) awake = 1'b1;
        end
    end

    always_comb begin
        new_ent.pid         = i_head.pid;
        new_ent.mtype       = i_head.mtype;
        new_ent.prio        = i_head.prio;
        new_ent.dst         = i_head.dst;
        new_ent.len         = i_head.len;
        new_ent.due_tick    = i_head.due_tick;
        new_ent.expiry_tick = i_head.expiry_tick;
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_count = r_count;
        n_fill  = r_fill;
        n_ptr   = r_ptr;
        n_pass  = r_pass;
        n_wait  = r_wait;
        n_res   = '0;
        o_pop   = 1'b0;
        push_en = 1'b0;
        rm_en   = 1'b0;
        rm_pos  = rd_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_head;
                    n_res.done = 1'b1;
                    unique case (i_head.func)
                        FN_CLEAR: begin
                            n_count = '0;
                            n_fill  = '0;
                        end
                        FN_PUSH: begin
                            if (i_head.dst != NO_DEST && i_head.dst == i_own_address) begin
                                n_res.status = ST_SELF;
                            end else if (r_count >= CNT_W'(DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else if ((FILL_W+1)'(r_fill) + (FILL_W+1)'(i_head.len)
                                         > (FILL_W+1)'(PAYLOAD_BYTES)) begin
                                n_res.status = ST_SPACE;
                            end else begin
                                push_en = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                n_fill  = r_fill + FILL_W'(i_head.len);
                            end
                        end
                        FN_POP: begin
                            if ((CNT_W+3)'(i_head.idx) >= (CNT_W+3)'(r_count)) begin
                                n_res.status = ST_BAD_IDX;
                            end else begin
                                n_res.pid   = rd.pid;
                                n_res.mtype = rd.mtype;
                                n_res.prio  = rd.prio;
                                n_res.dst   = rd.dst;
                                n_res.len   = rd.len;
                                rm_en   = 1'b1;
                                n_count = r_count - CNT_W'(1);
                                n_fill  = (r_fill >= FILL_W'(rd.len)) ?
                                          r_fill - FILL_W'(rd.len) : '0;
                            end
                        end
                        FN_READY: begin
                            n_res.done = 1'b0;
                            n_state = S_PURGE;
                            n_ptr   = r_count;
                            n_pass  = 1'b1;
                            n_wait  = '0;
                        end
                        FN_AWAKE: begin
                            n_res.awake = awake;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PURGE: begin
                if (r_ptr == '0) begin
                    n_state = S_SCAN;
                end else begin
                    if (rd.expiry_tick != 32'd0 && rd.expiry_tick < r_cmd.now) begin
                        rm_en   = 1'b1;
                        n_count = r_count - CNT_W'(1);
                        n_fill  = (r_fill >= FILL_W'(rd.len)) ?
                                  r_fill - FILL_W'(rd.len) : '0;
                    end
                    n_ptr = ptr_dec;
                end
            end
            default: begin
                if (r_count == '0) begin
                    n_res.done   = 1'b1;
                    n_res.status = ST_EMPTY;
                    n_state      = S_IDLE;
                end else if (r_ptr == r_count) begin
                    if (r_pass) begin
                        n_pass = 1'b0;
                        n_ptr  = '0;
                    end else begin
                        n_res.done       = 1'b1;
                        n_res.status     = ST_NONE;
                        n_res.wait_ticks = r_wait;
                        n_state          = S_IDLE;
                    end
                end else begin
                    if (rd.prio == r_pass) begin
                        if (rd.due_tick <= r_cmd.now) begin
                            n_res.done        = 1'b1;
                            n_res.ready_index = 3'(r_ptr);
                            n_state           = S_IDLE;
                        end else if (r_wait == 32'd0 || diff < r_wait) begin
                            n_wait = diff;
                        end
                    end
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end
        endcase
        n_res.queue_count = 4'(n_count);
    end

    // entry store: append at the tail, close the gap on removal
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH - 1; k++) begin
            if (rm_en && IDX_W'(k) >= rm_pos) r_ent[k] <= r_ent[k + 1];
        end
        if (push_en) r_ent[r_count[IDX_W-1:0]] <= new_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_fill  <= '0;
            r_ptr   <= '0;
            r_pass  <= 1'b0;
            r_wait  <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_fill  <= n_fill;
            r_ptr   <= n_ptr;
            r_pass  <= n_pass;
            r_wait  <= n_wait;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    `TPMQ_ASSERT_IMPL(a_count_max, 1'b1, r_count <= CNT_W'(DEPTH), "entry count over depth")
    `TPMQ_ASSERT_IMPL(a_fill_max, 1'b1, r_fill <= FILL_W'(PAYLOAD_BYTES), "payload fill over size")
    `TPMQ_ASSERT_IMPL(a_done_idle, r_res.done, r_state == S_IDLE, "result while still working")
    `TPMQ_ASSERT_IMPL(a_scan_ptr, r_state == S_SCAN, r_ptr <= r_count, "scan pointer past tail")
endmodule
`default_nettype wire

@@ hw/rtl/timed_priority_message_queue_top.sv @@
// ----------------------------------------------------------------------------
// timed_priority_message_queue_top
// Timed two-level priority queue of outgoing message descriptors.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Ports
// command   in   start && !busy     i_func .. i_index
// result    out  o_done strobe      o_status .. o_stay_awake
// config    in   i_cfg_we           i_cfg_wdata (own address)
//
// A command word waits in a two-word queue; busy is high when that queue is full.
// Push, pop, clear and stay-awake query are each handled in the back end's idle state.
// Ready check: a purge pass drops expired entries, then a scan takes priority entries first, then normal ones.
// Reset is synchronous, active low; it empties the queue.
// Results are shown for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
module timed_priority_message_queue_top import tpmq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_func,
    input  wire logic [31:0] i_now,
    input  wire logic [15:0] i_raw_pid,
    input  wire logic [7:0]  i_msg_type,
    input  wire logic [7:0]  i_data_len,
    input  wire logic        i_priority_req,
    input  wire logic [15:0] i_dst_did,
    input  wire logic [31:0] i_send_delay,
    input  wire logic [31:0] i_expire_delay,
    input  wire logic [2:0]  i_index,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [2:0]       o_ready_index,
    output logic [31:0]      o_wait_ticks,
    output logic [3:0]       o_queue_count,
    output logic [15:0]      o_pop_pid,
    output logic [7:0]       o_pop_msg_type,
    output logic             o_pop_priority,
    output logic [15:0]      o_pop_dst_did,
    output logic [7:0]       o_pop_len,
    output logic             o_stay_awake
);
    logic [15:0] r_own_address;
    logic        head_valid;
    t_cmd        head;
    logic        pop;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
        end else if (i_cfg_we) begin
            r_own_address <= i_cfg_wdata;
        end
    end

    tpmq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_func         (i_func),
        .i_now          (i_now),
        .i_raw_pid      (i_raw_pid),
        .i_msg_type     (i_msg_type),
        .i_data_len     (i_data_len),
        .i_priority_req (i_priority_req),
        .i_dst_did      (i_dst_did),
        .i_send_delay   (i_send_delay),
        .i_expire_delay (i_expire_delay),
        .i_index        (i_index),
        .i_pop          (pop),
        .o_full         (busy),
        .o_head_valid   (head_valid),
        .o_head         (head)
    );

    tpmq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_own_address (r_own_address),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_res         (res)
    );

    assign o_done         = res.done;
    assign o_status       = res.status;
    assign o_ready_index  = res.ready_index;
    assign o_wait_ticks   = res.wait_ticks;
    assign o_queue_count  = res.queue_count;
    assign o_pop_pid      = res.pid;
    assign o_pop_msg_type = res.mtype;
    assign o_pop_priority = res.prio;
    assign o_pop_dst_did  = res.dst;
    assign o_pop_len      = res.len;
    assign o_stay_awake   = res.awake;
endmodule
`default_nettype wire
